// File: sv/linear_interp_rate_converter_core_macros.svh
// Assertion helpers shared by the lri_phase and lri_merge modules.
`ifndef LINEAR_INTERP_RATE_CONVERTER_CORE_MACROS_SVH
`define LINEAR_INTERP_RATE_CONVERTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LRI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define LRI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define LRI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LRI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/lri_pkg.sv
`timescale 1ns / 1ps
package lri_pkg;

    localparam int OUT_PER_BLOCK_DEF = 1920;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CFG_W             = 14;
    localparam logic [CFG_W-1:0] CFG_RESET = 14'd2500;
    localparam int WEIGHT_W          = 16;
    localparam int FIFO_DEPTH        = 8;

    // Items in flight ahead of the lanes
    typedef struct packed {
        logic st1;
        logic st2;
    } lri_flight_t;

endpackage

// File: sv/linear_interp_rate_converter_core.sv
`timescale 1ns / 1ps
// A result word passes the st1 and st2 registers of lri_phase, the lane registers and the output buffer.
// Throughput: one input word per clock while s_tready is high; each input yields zero or one result word.
// The rate is held by an eight-word output buffer that reserves room for words in flight.
// Reset (aresetn low, synchronous): clears the phase, the held sample and the buffer,
// and sets input_per_block to 2500; no clearing pass, the block is ready right away.
module linear_interp_rate_converter_core #(
    parameter int OUT_PER_BLOCK = lri_pkg::OUT_PER_BLOCK_DEF,
    parameter int SAMPLE_BITS   = lri_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration: input_per_block
    input  logic                                  cfg_wr_en,
    input  logic [lri_pkg::CFG_W-1:0]             cfg_wr_data,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample_i, sample_q
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata   // out_i, out_q
);
    import lri_pkg::*;

    localparam int TW = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] in_i, in_q;
    lri_flight_t                   flight;
    logic [WEIGHT_W-1:0]           weight;
    logic signed [SAMPLE_BITS-1:0] a_i, a_q, b_i, b_q;
    logic                          lane_i_valid, lane_q_valid;
    logic signed [SAMPLE_BITS-1:0] res_i, res_q;
    logic [2*SAMPLE_BITS-1:0]      out_word;

    // unpack the input word, in-phase in the low half
    assign in_i   = s_tdata[SAMPLE_BITS-1:0];
    assign in_q   = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign accept = s_tvalid && s_tready;

    // phase tracker: holds the previous sample, advances the exact phase,
    // and turns the phase into a Q0.16 weight
    lri_phase #(
        .OUT_PER_BLOCK (OUT_PER_BLOCK),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_phase (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (accept),
        .in_i        (in_i),
        .in_q        (in_q),
        .flight      (flight),
        .weight      (weight),
        .a_i         (a_i),
        .a_q         (a_q),
        .b_i         (b_i),
        .b_q         (b_q)
    );

    // one interpolation lane per component, sharing the weight
    lri_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (flight.st2),
        .weight    (weight),
        .a         (a_i),
        .b         (b_i),
        .out_valid (lane_i_valid),
        .result    (res_i)
    );

    lri_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (flight.st2),
        .weight    (weight),
        .a         (a_q),
        .b         (b_q),
        .out_valid (lane_q_valid),
        .result    (res_q)
    );

    // join the lanes into one word and buffer it towards the result port
    lri_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .flight       (flight),
        .lane_i_valid (lane_i_valid),
        .lane_q_valid (lane_q_valid),
        .res_i        (res_i),
        .res_q        (res_q),
        .in_ready     (s_tready),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_word     (out_word)
    );

    // pad the result word with zeros up to whole bytes
    assign m_tdata = TW'(out_word);

endmodule

// File: sv/lri_phase.sv
`timescale 1ns / 1ps
`include "linear_interp_rate_converter_core_macros.svh"
module lri_phase #(
    parameter int OUT_PER_BLOCK = lri_pkg::OUT_PER_BLOCK_DEF,
    parameter int SAMPLE_BITS   = lri_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lri_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                               in_accept,
    input  logic signed [SAMPLE_BITS-1:0]      in_i,
    input  logic signed [SAMPLE_BITS-1:0]      in_q,
    output lri_pkg::lri_flight_t               flight,
    output logic [lri_pkg::WEIGHT_W-1:0]       weight,
    output logic signed [SAMPLE_BITS-1:0]      a_i,
    output logic signed [SAMPLE_BITS-1:0]      a_q,
    output logic signed [SAMPLE_BITS-1:0]      b_i,
    output logic signed [SAMPLE_BITS-1:0]      b_q
);
    import lri_pkg::*;

    localparam int PHW   = $clog2(OUT_PER_BLOCK);
    localparam int SHIFT = 2 * PHW;
    // ceil(2^(16+SHIFT) / M): exact floor of phase*2^16/M for any phase below M
    localparam longint unsigned RECIP =
        ((64'd1 << (WEIGHT_W + SHIFT)) + 64'(OUT_PER_BLOCK) - 64'd1) / 64'(OUT_PER_BLOCK);
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PRODW = PHW + RW;
    localparam logic [RW-1:0]    RECIP_V = RW'(RECIP);
    localparam logic [CFG_W-1:0] M_V     = CFG_W'(OUT_PER_BLOCK);

    logic [CFG_W-1:0] cfg_reg, cfg_next;
    logic [CFG_W-1:0] phase_reg, phase_next;
    logic             have_prev_reg, have_prev_next;
    logic signed [SAMPLE_BITS-1:0] prev_i_reg, prev_q_reg;

    logic             st1_reg, st1_next;
    logic [PHW-1:0]   ph1_reg;
    logic signed [SAMPLE_BITS-1:0] a1_i_reg, a1_q_reg, b1_i_reg, b1_q_reg;

    logic             st2_reg;
    logic [WEIGHT_W-1:0] w2_reg;
    logic signed [SAMPLE_BITS-1:0] a2_i_reg, a2_q_reg, b2_i_reg, b2_q_reg;

    logic [CFG_W-1:0] step;
    logic             emit;
    logic [CFG_W:0]   advanced;
    logic [PRODW-1:0] wprod;

    always_comb begin
        cfg_next = cfg_wr_en ? cfg_wr_data : cfg_reg;
        step     = (cfg_reg < M_V) ? M_V : cfg_reg;
        emit     = have_prev_reg && (phase_reg < M_V);
        advanced = {1'b0, phase_reg} + {1'b0, step} - {1'b0, M_V};

        phase_next     = phase_reg;
        have_prev_next = have_prev_reg;
        if (in_accept) begin
            have_prev_next = 1'b1;
            if (!have_prev_reg) begin
                phase_next = '0;
            end else if (emit) begin
                phase_next = advanced[CFG_W-1:0];
            end else begin
                phase_next = phase_reg - M_V;
            end
        end
        st1_next = in_accept && emit;

        wprod = PRODW'(ph1_reg) * PRODW'(RECIP_V);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= CFG_RESET;
            phase_reg     <= '0;
            have_prev_reg <= 1'b0;
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            st1_reg       <= 1'b0;
            st2_reg       <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            phase_reg     <= phase_next;
            have_prev_reg <= have_prev_next;
            if (in_accept) begin
                prev_i_reg <= in_i;
                prev_q_reg <= in_q;
            end
            st1_reg <= st1_next;
            st2_reg <= st1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ph1_reg  <= phase_reg[PHW-1:0];
        a1_i_reg <= prev_i_reg;
        a1_q_reg <= prev_q_reg;
        b1_i_reg <= in_i;
        b1_q_reg <= in_q;
        w2_reg   <= wprod[SHIFT +: WEIGHT_W];
        a2_i_reg <= a1_i_reg;
        a2_q_reg <= a1_q_reg;
        b2_i_reg <= b1_i_reg;
        b2_q_reg <= b1_q_reg;
    end

    assign flight.st1 = st1_reg;
    assign flight.st2 = st2_reg;
    assign weight     = w2_reg;
    assign a_i        = a2_i_reg;
    assign a_q        = a2_q_reg;
    assign b_i        = b2_i_reg;
    assign b_q        = b2_q_reg;

    `LRI_ASSERT_NXT(a_emit_starts, aclk, aresetn, in_accept && emit, st1_reg)
    `LRI_ASSERT_NXT(a_stage_moves, aclk, aresetn, st1_reg, st2_reg)
    `LRI_ASSERT_IMP(a_first_phase, aclk, aresetn, !have_prev_reg, phase_reg == '0 && !st1_next)

endmodule

// File: sv/lri_lane.sv
`timescale 1ns / 1ps
module lri_lane #(
    parameter int SAMPLE_BITS = lri_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [lri_pkg::WEIGHT_W-1:0]  weight,
    input  logic signed [SAMPLE_BITS-1:0] a,
    input  logic signed [SAMPLE_BITS-1:0] b,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] result
);
    import lri_pkg::*;

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = DW + WEIGHT_W + 1;
    localparam int SW = SAMPLE_BITS + 2;

    logic                 valid_reg;
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod_next, prod_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [SW-1:0] shifted, sum;
    logic                 fits;

    always_comb begin
        diff      = DW'(b) - DW'(a);
        prod_next = PW'(diff) * $signed({1'b0, weight});
        // floor(prod / 2^16): arithmetic shift by slice
        shifted   = prod_reg[WEIGHT_W +: SW];
        sum       = SW'(a_reg) + shifted;
        fits      = (sum[SW-1:SAMPLE_BITS-1] == '0) || (sum[SW-1:SAMPLE_BITS-1] == '1);
        if (fits) begin
            result = sum[SAMPLE_BITS-1:0];
        end else begin
            result = {sum[SW-1], {(SAMPLE_BITS-1){~sum[SW-1]}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        a_reg    <= a;
    end

    assign out_valid = valid_reg;

endmodule

// File: sv/lri_merge.sv
`timescale 1ns / 1ps
`include "linear_interp_rate_converter_core_macros.svh"
module lri_merge #(
    parameter int SAMPLE_BITS = lri_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lri_pkg::lri_flight_t          flight,
    input  logic                          lane_i_valid,
    input  logic                          lane_q_valid,
    input  logic signed [SAMPLE_BITS-1:0] res_i,
    input  logic signed [SAMPLE_BITS-1:0] res_q,
    output logic                          in_ready,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [2*SAMPLE_BITS-1:0]      out_word
);
    import lri_pkg::*;

    localparam int AW   = $clog2(FIFO_DEPTH);
    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam int OW   = $clog2(FIFO_DEPTH + 4);
    localparam int WW   = 2 * SAMPLE_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

    logic [WW-1:0] mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [OW-1:0] occupancy;
    logic          wr_en, rd_en;

    always_comb begin
        wr_en = lane_i_valid;
        rd_en = out_valid && out_ready;
        // reserve a slot for every word still on its way down the pipeline
        occupancy = OW'(count_reg) + OW'(flight.st1) + OW'(flight.st2) + OW'(lane_i_valid);
        in_ready  = occupancy < OW'(FIFO_DEPTH);

        wr_ptr_next = wr_en ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + CW'(1);
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= {res_q, res_i};
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rd_ptr_reg];

    `LRI_ASSERT_IMP(a_lanes_agree, aclk, aresetn, 1'b1, lane_i_valid == lane_q_valid)
    `LRI_ASSERT_IMP(a_no_overflow, aclk, aresetn, wr_en, (count_reg < DEPTH_C) || rd_en)
    `LRI_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_C)

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

    import lri_pkg::*;

    localparam int M_OUT    = OUT_PER_BLOCK_DEF;
    localparam int DRAIN    = 10;    // cycles after the last result before touching the register
    localparam int HOLD_LEN = 300;   // long receiver hold-off, in clocks

    typedef struct packed {
        logic signed [15:0] q;
        logic signed [15:0] i;
    } iq_word_t;

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata     = '0;   // sample_i [15:0], sample_q [31:16]
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [31:0]      m_tdata;            // out_i [15:0], out_q [31:16]

    // words waiting to be offered, and interpolated words still owed by the block
    iq_word_t pending_words[$];
    iq_word_t expected_outs[$];
    iq_word_t last_pushed;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int err_cnt    = 0;

    // resampler state as the block should hold it
    logic [CFG_W-1:0]   ratio_n    = CFG_RESET;
    logic signed [15:0] held_i     = '0;
    logic signed [15:0] held_q     = '0;
    int                 frac_pos   = 0;
    logic               held_valid = 1'b0;

    linear_interp_rate_converter_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // prev + floor((next - prev) * w / 65536), clamped to 16 bits signed
    function automatic logic signed [15:0] lerp_sat(longint a, longint b, longint w16);
        longint prod;
        longint r;
        prod = (b - a) * w16;
        r = a + (prod >>> 16);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // Advance the resampler by one input word; queue the output word if one falls here.
    task automatic predict_resample(iq_word_t w);
        int       stride;
        longint   w16;
        iq_word_t res;
        stride = (ratio_n < M_OUT) ? M_OUT : int'(ratio_n);
        if (!held_valid) begin
            // first word after reset is only held; output 0 sits on it
            held_valid = 1'b1;
            frac_pos = 0;
        end else begin
            if (frac_pos < M_OUT) begin
                w16 = (longint'(frac_pos) << 16) / M_OUT;
                res.i = lerp_sat(held_i, w.i, w16);
                res.q = lerp_sat(held_q, w.q, w16);
                expected_outs.push_back(res);
                frac_pos += stride;
            end
            frac_pos -= M_OUT;
        end
        held_i = w.i;
        held_q = w.q;
    endtask

    // Track register writes and accepted input words.
    always @(posedge aclk) begin
        if (!aresetn) begin
            ratio_n    = CFG_RESET;
            held_i     = '0;
            held_q     = '0;
            frac_pos   = 0;
            held_valid = 1'b0;
        end else begin
            if (cfg_wr_en)
                ratio_n = cfg_wr_data;
            if (s_tvalid && s_tready)
                predict_resample(iq_word_t'(s_tdata));
        end
    end

    // Sender: offer the next pending word once the current one is taken, idling at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= pending_words.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_seen <= hold_req;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each delivered word with the oldest one owed.
    always @(posedge aclk) begin
        iq_word_t got;
        iq_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            got = iq_word_t'(m_tdata);
            if (expected_outs.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected word i=%0d q=%0d", $time, got.i, got.q);
            end else begin
                exp_w = expected_outs.pop_front();
                if (got.i !== exp_w.i) begin
                    err_cnt++;
                    $display("%0t: out_i expected %0d got %0d", $time, exp_w.i, got.i);
                end
                if (got.q !== exp_w.q) begin
                    err_cnt++;
                    $display("%0t: out_q expected %0d got %0d", $time, exp_w.q, got.q);
                end
            end
        end
    end

    task automatic push_word(int vi, int vq);
        iq_word_t w;
        w.i = vi[15:0];
        w.q = vq[15:0];
        pending_words.push_back(w);
        last_pushed = w;
    endtask

    // Mix of full-range noise, rail values and small steps from the last word.
    function automatic iq_word_t random_iq_word();
        iq_word_t w;
        logic [15:0] rails[4];
        int kind;
        rails[0] = 16'h8000;
        rails[1] = 16'h7fff;
        rails[2] = 16'h0000;
        rails[3] = 16'hffff;
        kind = $urandom_range(9);
        if (kind < 5) begin
            w = $urandom;
        end else if (kind < 7) begin
            w.i = rails[$urandom_range(3)];
            w.q = rails[$urandom_range(3)];
        end else begin
            w.i = last_pushed.i + 16'($urandom_range(64)) - 16'sd32;
            w.q = last_pushed.q + 16'($urandom_range(64)) - 16'sd32;
        end
        return w;
    endfunction

    // Hold until every word has been offered and taken and every output has arrived.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_outs.size() != 0);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic write_ratio(logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(logic [CFG_W-1:0] v, int sidle, int rstall, int count,
                                bit long_hold);
        iq_word_t w;
        write_ratio(v);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (int k = 0; k < count; k++) begin
            w = random_iq_word();
            push_word(w.i, w.q);
        end
        if (long_hold) begin
            // sender keeps offering while the output side is held off
            @(posedge aclk);
            hold_req <= hold_req + 1;
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset ratio: first word only held, then rail-to-rail swings.
        push_word(0, 0);
        push_word(32767, -32768);
        push_word(-32768, 32767);
        push_word(32767, 32767);
        push_word(-32768, -32768);
        push_word(-1, 1);
        push_word(0, -1);
        push_word(12345, -12345);
        push_word(100, 200);
        push_word(-5, -7);
        wait_drained();

        // One output per input once the phase carried over from the previous ratio is below the output count.
        write_ratio(14'd1920);
        push_word(32767, -32768);
        push_word(-32768, 32767);
        push_word(32767, -32768);
        push_word(0, 0);
        push_word(-1, -1);
        push_word(1, 1);
        wait_drained();

        // Ratio below the output count is clamped up to it.
        write_ratio(14'd1000);
        push_word(-32768, -32768);
        push_word(32767, 32767);
        push_word(-2, 3);
        push_word(0, 0);
        wait_drained();

        // Random part: register extremes and the idling patterns.
        random_phase(14'd0,     0,  0,  200, 1'b1);
        random_phase(14'd10000, 58, 0,  150, 1'b0);
        random_phase(14'h3fff,  0,  58, 150, 1'b0);
        random_phase(14'd1920,  10, 10, 200, 1'b0);
        random_phase(14'($urandom_range(1920, 3000)),  0,  0,  100, 1'b0);
        random_phase(14'($urandom_range(1920, 10000)), 58, 0,  100, 1'b0);
        random_phase(14'($urandom_range(0, 16383)),    0,  58, 100, 1'b0);
        random_phase(14'($urandom_range(1920, 2600)),  10, 10, 100, 1'b0);

        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
